// File: rtl/core/psfq_pkg.sv
// Package for the per-stream frame queues core: status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package psfq_pkg;
   localparam int STATUS_W = 3;
   localparam int MAX_RESULTS = 16;
   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_EVICTED = 3'd1,
      ST_FULL    = 3'd2,
      ST_POPPED  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SEARCH,
      FSM_PUSH_RD,
      FSM_PUSH_WR,
      FSM_POP_SCAN,
      FSM_POP_RD,
      FSM_POP_OUT
   } fsm_type;
endpackage

// File: rtl/core/per_stream_frame_queues_core.sv
// Timing: a push is busy for the serial slot search, entry read and entry write,
// a rejected push for the search alone; the result shows in the first cycle with busy low.
// A pop-all is busy for the serial scan plus a read and an output per frame; one item at a time.
// Results cannot be stalled: each shows for one cycle with rsp_valid.
// Synchronous reset clears slot use, heads, counts and sets max_queued to 16.
`timescale 1ns / 1ps
module per_stream_frame_queues_core #(
   parameter int STREAM_SLOTS = 16,
   parameter int QUEUE_DEPTH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [15:0] req_stream_id,
   input  logic [31:0] req_frame_handle,
   input  logic [15:0] req_frame_bytes,
   input  logic [47:0] req_frame_stamp,
   input  logic [47:0] req_arrival_time,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_max_queued,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_stream,
   output logic [31:0] rsp_out_handle,
   output logic [15:0] rsp_out_bytes,
   output logic [47:0] rsp_out_stamp,
   output logic [47:0] rsp_out_arrival,
   output logic        rsp_last
);
   import psfq_pkg::*;

   localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PSW = CW + 1;
   localparam int SCW = $clog2(STREAM_SLOTS + 1);
   localparam int AW = SW + QW;
   localparam int EW = 32 + 16 + 48 + 48;
   localparam int RCW = $clog2(MAX_RESULTS + 1);

   fsm_type state_ff, state_in;
   logic [4:0]  maxq_ff;
   logic        cmd_ff;
   logic [15:0] sid_ff;
   logic [EW-1:0] frame_ff;
   logic [STREAM_SLOTS-1:0] used_ff;
   logic [15:0] stream_ff [STREAM_SLOTS];
   logic [QW-1:0] head_ff [STREAM_SLOTS];
   logic [CW-1:0] count_ff [STREAM_SLOTS];
   logic [SCW-1:0] scan_ff, scan_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          hit_ff, hit_in, free_ff, free_in;
   logic [SW-1:0] free_slot_ff, free_slot_in;
   logic [RCW-1:0] npop_ff, npop_in;
   logic [EW-1:0] mem [STREAM_SLOTS << QW];
   logic [EW-1:0] rd_data_ff;
   logic          mem_re, mem_we;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] limit;
   logic [SW-1:0] scan_idx;
   logic          evict;
   logic [PSW-1:0] pos_sum;
   logic [QW-1:0] wr_pos, head_inc;
   logic          out_v_ff;
   logic [2:0]    out_st_ff;
   logic [15:0]   out_sid_ff;
   logic [EW-1:0] out_fr_ff;
   logic          out_last_ff;
   logic          any_left;

   assign scan_idx = scan_ff[SW-1:0];
   assign busy = (state_ff != FSM_IDLE);
   assign csr_ready = !busy && !start;

   always_comb begin
      if (maxq_ff == 5'd0) limit = CW'(1);
      else if (32'(maxq_ff) > QUEUE_DEPTH) limit = CW'(QUEUE_DEPTH);
      else limit = CW'(maxq_ff);
   end
   assign evict = (count_ff[slot_ff] >= limit);

   // wrap positions at the queue depth
   assign pos_sum = PSW'(head_ff[slot_ff]) + PSW'(count_ff[slot_ff]);
   assign wr_pos = (pos_sum >= PSW'(QUEUE_DEPTH)) ? QW'(pos_sum - PSW'(QUEUE_DEPTH))
                                                  : QW'(pos_sum);
   assign head_inc = (head_ff[slot_ff] == QW'(QUEUE_DEPTH - 1)) ? '0
                                                               : head_ff[slot_ff] + 1'b1;

   // more slots with frames after the current one
   always_comb begin
      any_left = 1'b0;
      for (int i = 0; i < STREAM_SLOTS; i++)
         if (i > 32'(slot_ff) && used_ff[i] && count_ff[i] != '0) any_left = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      slot_in = slot_ff;
      hit_in = hit_ff;
      free_in = free_ff;
      free_slot_in = free_slot_ff;
      npop_in = npop_ff;
      mem_re = 1'b0;
      mem_we = 1'b0;
      rd_addr = {slot_ff, head_ff[slot_ff]};
      wr_addr = {slot_ff, wr_pos};
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               scan_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               npop_in = '0;
               state_in = req_cmd ? FSM_POP_SCAN : FSM_SEARCH;
            end
         end
         FSM_SEARCH: begin
            if (scan_ff == SCW'(STREAM_SLOTS)) begin
               if (hit_ff) state_in = FSM_PUSH_RD;
               else if (free_ff) begin
                  slot_in = free_slot_ff;
                  state_in = FSM_PUSH_RD;
               end else state_in = FSM_IDLE;
            end else begin
               if (used_ff[scan_idx] && stream_ff[scan_idx] == sid_ff && !hit_ff) begin
                  hit_in = 1'b1;
                  slot_in = scan_idx;
               end
               if (!used_ff[scan_idx] && !free_ff) begin
                  free_in = 1'b1;
                  free_slot_in = scan_idx;
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         FSM_PUSH_RD: begin
            mem_re = 1'b1;
            state_in = FSM_PUSH_WR;
         end
         FSM_PUSH_WR: begin
            mem_we = 1'b1;
            state_in = FSM_IDLE;
         end
         FSM_POP_SCAN: begin
            if (scan_ff == SCW'(STREAM_SLOTS)) state_in = FSM_IDLE;
            else if (used_ff[scan_idx] && count_ff[scan_idx] != '0) begin
               slot_in = scan_idx;
               state_in = FSM_POP_RD;
            end else scan_in = scan_ff + 1'b1;
         end
         FSM_POP_RD: begin
            mem_re = 1'b1;
            state_in = FSM_POP_OUT;
         end
         FSM_POP_OUT: begin
            npop_in = npop_ff + 1'b1;
            scan_in = scan_ff + 1'b1;
            if (!any_left || npop_in == RCW'(MAX_RESULTS)) state_in = FSM_IDLE;
            else state_in = FSM_POP_SCAN;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= frame_ff;
      if (mem_re) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         maxq_ff <= 5'd16;
         used_ff <= '0;
         out_v_ff <= 1'b0;
         for (int i = 0; i < STREAM_SLOTS; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_v_ff <= 1'b0;
         if (csr_valid && csr_ready) maxq_ff <= csr_max_queued;
         if (state_ff == FSM_IDLE && start) begin
            cmd_ff <= req_cmd;
            sid_ff <= req_stream_id;
            frame_ff <= {req_frame_handle, req_frame_bytes, req_frame_stamp, req_arrival_time};
         end
         if (state_ff == FSM_SEARCH && scan_ff == SCW'(STREAM_SLOTS)) begin
            if (!hit_ff && free_ff) begin
               used_ff[free_slot_ff] <= 1'b1;
               stream_ff[free_slot_ff] <= sid_ff;
               head_ff[free_slot_ff] <= '0;
               count_ff[free_slot_ff] <= '0;
            end else if (!hit_ff) begin
               out_v_ff <= 1'b1;
               out_st_ff <= ST_FULL;
               out_sid_ff <= sid_ff;
               out_fr_ff <= frame_ff;
               out_last_ff <= 1'b1;
            end
         end
         if (state_ff == FSM_PUSH_WR) begin
            out_v_ff <= 1'b1;
            out_last_ff <= 1'b1;
            if (evict) begin
               head_ff[slot_ff] <= head_inc;
               out_st_ff <= ST_EVICTED;
               out_sid_ff <= sid_ff;
               out_fr_ff <= rd_data_ff;
            end else begin
               count_ff[slot_ff] <= count_ff[slot_ff] + 1'b1;
               out_st_ff <= ST_STORED;
               out_sid_ff <= '0;
               out_fr_ff <= '0;
            end
         end
         if (state_ff == FSM_POP_SCAN && scan_ff == SCW'(STREAM_SLOTS)) begin
            out_v_ff <= 1'b1;
            out_st_ff <= ST_EMPTY;
            out_sid_ff <= '0;
            out_fr_ff <= '0;
            out_last_ff <= 1'b1;
         end
         if (state_ff == FSM_POP_OUT) begin
            head_ff[slot_ff] <= head_inc;
            count_ff[slot_ff] <= count_ff[slot_ff] - 1'b1;
            out_v_ff <= 1'b1;
            out_st_ff <= ST_POPPED;
            out_sid_ff <= stream_ff[slot_ff];
            out_fr_ff <= rd_data_ff;
            out_last_ff <= (state_in == FSM_IDLE);
         end
      end
      scan_ff <= scan_in;
      slot_ff <= slot_in;
      hit_ff <= hit_in;
      free_ff <= free_in;
      free_slot_ff <= free_slot_in;
      npop_ff <= npop_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_status = out_st_ff;
   assign rsp_out_stream = out_sid_ff;
   assign {rsp_out_handle, rsp_out_bytes, rsp_out_stamp, rsp_out_arrival} = out_fr_ff;
   assign rsp_last = out_last_ff;

   a_push_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_PUSH_WR |=> rsp_valid && rsp_last) else $error("push result missing");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("busy after last result");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_PUSH_WR |-> 32'(count_ff[slot_ff]) <= QUEUE_DEPTH)
      else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_POP_RD |-> count_ff[slot_ff] != '0) else $error("pop from empty queue");
   a_cmd_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_POP_OUT |-> cmd_ff) else $error("pop path on push");
endmodule

// File: verif/tb.sv
// Testbench for per_stream_frame_queues_core: random push / pop-all traffic checked
// against a behavioral model of the per-stream drop-oldest queues.
// Depends on psfq_pkg and the core RTL.
`timescale 1ns / 1ps
module tb;
   import psfq_pkg::*;

   localparam int SLOTS = 16;
   localparam int DEPTH = 16;
   localparam int LIMIT = 20000;
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [15:0] sid;
      logic [31:0] handle;
      logic [15:0] nbytes;
      logic [47:0] stamp;
      logic [47:0] arrival;
   } frame_cmd_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] sid;
      logic [31:0] handle;
      logic [15:0] nbytes;
      logic [47:0] stamp;
      logic [47:0] arrival;
      logic        last;
   } frame_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = 1'b0;
   logic [15:0] req_stream_id = '0;
   logic [31:0] req_frame_handle = '0;
   logic [15:0] req_frame_bytes = '0;
   logic [47:0] req_frame_stamp = '0;
   logic [47:0] req_arrival_time = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_max_queued = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [15:0] rsp_out_stream;
   logic [31:0] rsp_out_handle;
   logic [15:0] rsp_out_bytes;
   logic [47:0] rsp_out_stamp;
   logic [47:0] rsp_out_arrival;
   logic rsp_last;

   per_stream_frame_queues_core i_dut (.*);

   always #4 clock = ~clock;

   // queue model
   logic [4:0]  q_limit;
   logic        slot_open [SLOTS];
   logic [15:0] slot_sid [SLOTS];
   logic [3:0]  q_head [SLOTS];
   logic [4:0]  q_fill [SLOTS];
   frame_cmd_type q_store [SLOTS][DEPTH];

   frame_cmd_type pending_cmds[$];
   frame_rsp_type expected_rsps[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   logic accepted_last = 1'b0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   function automatic frame_rsp_type mk_rsp(status_type st, frame_cmd_type f, logic lst);
      frame_rsp_type r;
      r.status = st; r.sid = f.sid; r.handle = f.handle; r.nbytes = f.nbytes;
      r.stamp = f.stamp; r.arrival = f.arrival; r.last = lst;
      return r;
   endfunction

   function automatic frame_cmd_type take_oldest(int s);
      frame_cmd_type f;
      f = q_store[s][q_head[s]];
      q_head[s] = q_head[s] + 4'd1;
      q_fill[s] = q_fill[s] - 5'd1;
      return f;
   endfunction

   task automatic predict_frames(input frame_cmd_type c);
      int lim, s, n;
      frame_cmd_type f, z;
      frame_rsp_type rs[$];
      z = '0;
      if (c.cmd == CMD_PUSH) begin
         lim = (q_limit < 1) ? 1 : (q_limit > DEPTH ? DEPTH : q_limit);
         s = -1;
         for (int i = 0; i < SLOTS; i++)
            if (s < 0 && slot_open[i] && slot_sid[i] == c.sid) s = i;
         if (s < 0) begin
            for (int i = 0; i < SLOTS; i++)
               if (s < 0 && !slot_open[i]) s = i;
            if (s < 0) begin
               expected_rsps.push_back(mk_rsp(ST_FULL, c, 1'b1));
               return;
            end
            slot_open[s] = 1'b1; slot_sid[s] = c.sid; q_head[s] = '0; q_fill[s] = '0;
         end
         if (q_fill[s] >= lim) begin
            f = take_oldest(s);
            f.sid = c.sid;
            expected_rsps.push_back(mk_rsp(ST_EVICTED, f, 1'b1));
         end else begin
            expected_rsps.push_back(mk_rsp(ST_STORED, z, 1'b1));
         end
         q_store[s][q_head[s] + q_fill[s][3:0]] = c;
         q_fill[s] = q_fill[s] + 5'd1;
      end else begin
         n = 0;
         for (int i = 0; i < SLOTS; i++)
            if (n < MAX_RESULTS && slot_open[i] && q_fill[i] > 0) begin
               f = take_oldest(i);
               f.sid = slot_sid[i];
               rs.push_back(mk_rsp(ST_POPPED, f, 1'b0));
               n++;
            end
         if (n == 0) rs.push_back(mk_rsp(ST_EMPTY, z, 1'b1));
         else rs[n-1].last = 1'b1;
         foreach (rs[k]) expected_rsps.push_back(rs[k]);
      end
   endtask

   // driver: hold an item until its transfer, then advance
   always @(negedge clock) begin
      if (!reset && (!start || accepted_last)) begin
         if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            start <= 1'b1;
            req_cmd <= pending_cmds[0].cmd;
            req_stream_id <= pending_cmds[0].sid;
            req_frame_handle <= pending_cmds[0].handle;
            req_frame_bytes <= pending_cmds[0].nbytes;
            req_frame_stamp <= pending_cmds[0].stamp;
            req_arrival_time <= pending_cmds[0].arrival;
            void'(pending_cmds.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_rsp_type e;
      frame_cmd_type c;
      logic moved;
      moved = 1'b0;
      accepted_last <= !reset && start && !busy;
      if (!reset) begin
         if (start && !busy) begin
            c.cmd = req_cmd; c.sid = req_stream_id; c.handle = req_frame_handle;
            c.nbytes = req_frame_bytes; c.stamp = req_frame_stamp;
            c.arrival = req_arrival_time;
            predict_frames(c);
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            q_limit = csr_max_queued;
            moved = 1'b1;
         end
         if (rsp_valid) begin
            moved = 1'b1;
            if (expected_rsps.size() == 0) begin
               report("unexpected result status", rsp_status, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status != e.status) report("status", rsp_status, e.status);
               if (rsp_out_stream != e.sid) report("out_stream", rsp_out_stream, e.sid);
               if (rsp_out_handle != e.handle) report("out_handle", rsp_out_handle, e.handle);
               if (rsp_out_bytes != e.nbytes) report("out_bytes", rsp_out_bytes, e.nbytes);
               if (rsp_out_stamp != e.stamp) report("out_stamp", rsp_out_stamp, e.stamp);
               if (rsp_out_arrival != e.arrival)
                  report("out_arrival", rsp_out_arrival, e.arrival);
               if (rsp_last != e.last) report("last", rsp_last, e.last);
            end
         end
         if (moved) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   function automatic frame_cmd_type rand_push(int nsid);
      frame_cmd_type f;
      f.cmd = CMD_PUSH;
      f.sid = (nsid > 0) ? 16'($urandom_range(nsid - 1, 0) * 16'h1111) : 16'($urandom);
      f.handle = $urandom;
      f.nbytes = 16'($urandom);
      f.stamp = {16'($urandom), 32'($urandom)};
      f.arrival = {16'($urandom), 32'($urandom)};
      return f;
   endfunction

   function automatic frame_cmd_type pop_cmd();
      frame_cmd_type f;
      f = '0;
      f.cmd = CMD_POP;
      f.sid = 16'($urandom);
      f.handle = $urandom;
      return f;
   endfunction

   task automatic drain();
      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (start || busy || expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [4:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_queued <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      frame_cmd_type f;
      for (int i = 0; i < SLOTS; i++) begin
         slot_open[i] = 1'b0; slot_sid[i] = '0; q_head[i] = '0; q_fill[i] = '0;
      end
      q_limit = 5'd16;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, field extremes, fill one stream past depth
      pending_cmds.push_back(pop_cmd());
      f = '0; pending_cmds.push_back(f);
      f = '1; f.cmd = CMD_PUSH; pending_cmds.push_back(f);
      for (int i = 0; i < 17; i++) begin
         f = rand_push(0); f.sid = 16'h00AA; pending_cmds.push_back(f);
      end
      pending_cmds.push_back(pop_cmd());
      drain();

      // fill every slot, then reject a new id
      write_limit(5'd0);
      for (int i = 0; i < 15; i++) begin
         f = rand_push(0); f.sid = 16'h0100 + 16'(i); pending_cmds.push_back(f);
      end
      f = rand_push(0); f.sid = 16'hBEEF; pending_cmds.push_back(f);
      for (int i = 0; i < 3; i++) pending_cmds.push_back(pop_cmd());
      drain();

      send_idle_pct = 59;
      write_limit(5'd31);
      for (int i = 0; i < 16; i++) begin
         f = rand_push(0); f.sid = 16'h0100 + 16'($urandom_range(15, 0));
         pending_cmds.push_back(f);
      end
      drain();
      write_limit(5'd3);
      send_idle_pct = 0;
      for (int i = 0; i < 40; i++) begin
         f = rand_push(0); f.sid = 16'h0100 + 16'($urandom_range(15, 0));
         pending_cmds.push_back(i % 6 == 5 ? pop_cmd() : f);
      end
      drain();
      write_limit(5'd16);
      send_idle_pct = 13;
      for (int i = 0; i < 50; i++) begin
         f = rand_push(0); f.sid = (i % 5 == 0) ? 16'($urandom) :
                                   16'h0100 + 16'($urandom_range(15, 0));
         pending_cmds.push_back(i % 7 == 6 ? pop_cmd() : f);
      end
      for (int i = 0; i < 20; i++) pending_cmds.push_back(pop_cmd());
      drain();
      write_limit(5'd1);
      send_idle_pct = 59;
      for (int i = 0; i < 10; i++) begin
         f = rand_push(0); f.sid = 16'h0100 + 16'($urandom_range(15, 0));
         pending_cmds.push_back(f);
      end
      drain();
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
